FILE: hw/rtl/grid_field_barycentric_interp_core_defines.svh
// Assertion macros for the interpolation core
`ifndef GRID_FIELD_BARYCENTRIC_INTERP_CORE_DEFINES_SVH
`define GRID_FIELD_BARYCENTRIC_INTERP_CORE_DEFINES_SVH

`define GFB_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");

`define GFB_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");

`endif

FILE: hw/rtl/gfb_pkg.sv
package gfb_pkg;
	localparam int GRID_POINTS_DEF = 64;
	localparam logic [31:0] INV_SPACING_RST = 32'd4294967;
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_QUERY = 1'b1;
	localparam logic SEL_DEP = 1'b0;
	localparam logic SEL_EP = 1'b1;

	typedef struct packed {
		logic               kind;
		logic               table_select;
		logic [5:0]         grid_col;
		logic [5:0]         grid_row;
		logic signed [31:0] load_x;
		logic signed [31:0] load_y;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic               with_ep;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] dep_x;
		logic signed [31:0] dep_y;
		logic signed [31:0] ep_x;
		logic signed [31:0] ep_y;
		logic               out_of_grid;
	} out_item_t;

	function automatic logic signed [31:0] sat_round(input logic signed [63:0] acc);
		logic signed [63:0] r;
		r = (acc + 64'sd32768) >>> 16;
		if (r > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (r < -64'sd2147483648) return 32'sh80000000;
		return r[31:0];
	endfunction
endpackage

FILE: hw/rtl/grid_field_barycentric_interp_core.sv
// Channel   Handshake           Payload
// in        start && !busy      in_item (in_item_t)
// cfg       cfg_we              cfg_wdata (inv_spacing)
// out       done strobe         result (out_item_t)
// One item per cycle; a query's result is registered in every pipeline stage and appears with done.
// busy is always low: the receiver cannot stall, so the pipeline never holds.
// Reset clears valid bits and restores inv_spacing to its default;
// grid memories are undefined until loaded.
// A load is written to every bank of its grid in the cycle after its transfer.
`include "grid_field_barycentric_interp_core_defines.svh"
module grid_field_barycentric_interp_core #(
	parameter int GRID_POINTS = gfb_pkg::GRID_POINTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  gfb_pkg::in_item_t in_item,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_wdata,
	output logic              done,
	output gfb_pkg::out_item_t result
);
	import gfb_pkg::*;

	localparam int CELLS = GRID_POINTS * GRID_POINTS;
	localparam int AW = $clog2(CELLS);
	localparam int IW = $clog2(GRID_POINTS);
	localparam logic signed [47:0] OFF = 48'(((GRID_POINTS - 1) / 2)) <<< 16;

	logic [31:0] inv_q;
	logic [63:0] dep_mem0 [CELLS];
	logic [63:0] dep_mem1 [CELLS];
	logic [63:0] dep_mem2 [CELLS];
	logic [63:0] ep_mem0 [CELLS];
	logic [63:0] ep_mem1 [CELLS];
	logic [63:0] ep_mem2 [CELLS];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= INV_SPACING_RST;
		end else if (cfg_we) begin
			inv_q <= cfg_wdata;
		end
	end

	// stage 1: multiply
	logic v_s1, ld_s1, sel_s1, ep_s1;
	logic [AW-1:0] la_s1;
	logic [63:0] ldat_s1;
	logic signed [64:0] px_s1, py_s1;
	logic lok;
	assign lok = (32'(in_item.grid_col) < GRID_POINTS) && (32'(in_item.grid_row) < GRID_POINTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			ld_s1 <= 1'b0;
		end else begin
			v_s1 <= start && in_item.kind == KIND_QUERY;
			ld_s1 <= start && in_item.kind == KIND_LOAD && lok;
		end
	end
	always_ff @(posedge clk) begin
		sel_s1 <= in_item.table_select;
		ep_s1 <= in_item.with_ep;
		la_s1 <= AW'(32'(in_item.grid_col) * GRID_POINTS + 32'(in_item.grid_row));
		ldat_s1 <= {in_item.load_x, in_item.load_y};
		px_s1 <= in_item.pos_x * $signed({1'b0, inv_q});
		py_s1 <= in_item.pos_y * $signed({1'b0, inv_q});
	end

	always_ff @(posedge clk) begin
		if (ld_s1 && sel_s1 == SEL_DEP) begin
			dep_mem0[la_s1] <= ldat_s1;
			dep_mem1[la_s1] <= ldat_s1;
			dep_mem2[la_s1] <= ldat_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (ld_s1 && sel_s1 == SEL_EP) begin
			ep_mem0[la_s1] <= ldat_s1;
			ep_mem1[la_s1] <= ldat_s1;
			ep_mem2[la_s1] <= ldat_s1;
		end
	end

	// stage 2: triangle, weights, addresses
	logic signed [47:0] dx, dy, ix, iy;
	logic rx, ry;
	logic signed [47:0] x0, x1, y0, y2;
	logic bad;
	assign dx = 48'(px_s1 >>> 32) + OFF;
	assign dy = 48'(py_s1 >>> 32) + OFF;
	assign ix = dx >>> 16;
	assign iy = dy >>> 16;
	assign rx = dx[15];
	assign ry = dy[15];
	assign x0 = rx ? ix + 48'sd1 : ix;
	assign x1 = rx ? ix : ix + 48'sd1;
	assign y0 = ry ? iy + 48'sd1 : iy;
	assign y2 = ry ? iy : iy + 48'sd1;
	assign bad = ix < 0 || ix + 48'sd1 > 48'(GRID_POINTS - 1) ||
		iy < 0 || iy + 48'sd1 > 48'(GRID_POINTS - 1);

	logic signed [17:0] u, vv, su, sv, w0, w1, w2;
	assign u = 18'(dx - (x0 <<< 16));
	assign vv = 18'(dy - (y2 <<< 16));
	// fold in det: w0 = sx*u + sy*v, w1 = -sx*u, w2 = 1 - sy*v
	assign su = rx ? u : -u;
	assign sv = ry ? vv : -vv;
	assign w0 = su + sv;
	assign w1 = -su;
	assign w2 = 18'sd65536 - sv;

	logic v_s2, ep_s2, bad_s2;
	logic signed [17:0] w_s2 [3];
	logic [AW-1:0] a_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		ep_s2 <= ep_s1;
		bad_s2 <= bad;
		w_s2[0] <= w0;
		w_s2[1] <= w1;
		w_s2[2] <= w2;
		a_s2[0] <= AW'(x0[IW:0] * GRID_POINTS + y0[IW:0]);
		a_s2[1] <= AW'(x1[IW:0] * GRID_POINTS + y0[IW:0]);
		a_s2[2] <= AW'(x0[IW:0] * GRID_POINTS + y2[IW:0]);
	end

	// stage 3: memory read (three banked copies per grid)
	logic v_s3, ep_s3, bad_s3;
	logic signed [17:0] w_s3 [3];
	logic [63:0] dv_s3 [3];
	logic [63:0] ev_s3 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		ep_s3 <= ep_s2;
		bad_s3 <= bad_s2;
		for (int k = 0; k < 3; k++)
			w_s3[k] <= w_s2[k];
		dv_s3[0] <= dep_mem0[a_s2[0]];
		dv_s3[1] <= dep_mem1[a_s2[1]];
		dv_s3[2] <= dep_mem2[a_s2[2]];
		ev_s3[0] <= ep_mem0[a_s2[0]];
		ev_s3[1] <= ep_mem1[a_s2[1]];
		ev_s3[2] <= ep_mem2[a_s2[2]];
	end

	// stage 4: products
	logic v_s4, ep_s4, bad_s4;
	logic signed [49:0] pr_s4 [12];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		ep_s4 <= ep_s3;
		bad_s4 <= bad_s3;
		for (int k = 0; k < 3; k++) begin
			pr_s4[k]     <= w_s3[k] * $signed(dv_s3[k][63:32]);
			pr_s4[k + 3] <= w_s3[k] * $signed(dv_s3[k][31:0]);
			pr_s4[k + 6] <= w_s3[k] * $signed(ev_s3[k][63:32]);
			pr_s4[k + 9] <= w_s3[k] * $signed(ev_s3[k][31:0]);
		end
	end

	// stage 5: sums
	logic v_s5, ep_s5, bad_s5;
	logic signed [63:0] acc_s5 [4];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		ep_s5 <= ep_s4;
		bad_s5 <= bad_s4;
		for (int j = 0; j < 4; j++)
			acc_s5[j] <= 64'(pr_s4[3 * j]) + 64'(pr_s4[3 * j + 1]) + 64'(pr_s4[3 * j + 2]);
	end

	// stage 6: round, saturate, output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= v_s5;
	end
	always_ff @(posedge clk) begin
		result.out_of_grid <= bad_s5;
		result.dep_x <= bad_s5 ? 32'sd0 : sat_round(acc_s5[0]);
		result.dep_y <= bad_s5 ? 32'sd0 : sat_round(acc_s5[1]);
		result.ep_x <= (bad_s5 || !ep_s5) ? 32'sd0 : sat_round(acc_s5[2]);
		result.ep_y <= (bad_s5 || !ep_s5) ? 32'sd0 : sat_round(acc_s5[3]);
	end

	`GFB_ASSERT_NEXT(a_query_flows, clk, arst_n, v_s4, v_s5 ##1 done)
	`GFB_ASSERT_IMPL(a_no_ld_and_q, clk, arst_n, v_s1, !ld_s1)
	`GFB_ASSERT_NEXT(a_load_silent, clk, arst_n, start && in_item.kind == KIND_LOAD, !v_s1)
endmodule

FILE: dv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gfb_pkg::*;

	localparam int NPTS = GRID_POINTS_DEF;
	localparam longint CENTRE = longint'((NPTS - 1) / 2) <<< 16;
	localparam int WLO = (NPTS - 1) / 2 - 7;
	localparam int WHI = (NPTS - 1) / 2 + 8;

	typedef struct {
		in_item_t  item;
		bit        typed;
		out_item_t want;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	in_item_t   in_item = '0;
	logic       cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic       done;
	out_item_t  result;

	logic [31:0] inv_spacing_q = INV_SPACING_RST;
	int          grid_x [2][NPTS*NPTS];
	int          grid_y [2][NPTS*NPTS];
	out_item_t   pending_results [$];
	bit          failed = 1'b0;
	bit          calm;

	grid_field_barycentric_interp_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_item(in_item),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .result(result)
	);

	always #6 clk = ~clk;

	function automatic logic signed [31:0] round_sat(longint acc);
		longint s;
		s = (acc + 64'sd32768) >>> 16;
		if (s > 64'sd2147483647) s = 64'sd2147483647;
		if (s < -64'sd2147483648) s = -64'sd2147483648;
		return s[31:0];
	endfunction

	function automatic out_item_t interpolate(in_item_t it);
		longint dx, dy, ix, iy, u, v, det, ax, ay;
		longint xs [3], ys [3], w [3];
		int a;
		out_item_t r;
		r = '0;
		dx = ((longint'(it.pos_x) * longint'({32'b0, inv_spacing_q})) >>> 32) + CENTRE;
		dy = ((longint'(it.pos_y) * longint'({32'b0, inv_spacing_q})) >>> 32) + CENTRE;
		ix = dx >>> 16;
		iy = dy >>> 16;
		if (dx[15]) begin
			xs = '{ix + 1, ix, ix + 1};
		end else begin
			xs = '{ix, ix + 1, ix};
		end
		if (dy[15]) begin
			ys = '{iy + 1, iy + 1, iy};
		end else begin
			ys = '{iy, iy, iy + 1};
		end
		for (int k = 0; k < 3; k++)
			if (xs[k] < 0 || xs[k] > NPTS - 1 || ys[k] < 0 || ys[k] > NPTS - 1) begin
				r.out_of_grid = 1'b1;
				return r;
			end
		det = (xs[2] - xs[1]) * (ys[0] - ys[2]);
		u = dx - (xs[2] <<< 16);
		v = dy - (ys[2] <<< 16);
		w[0] = det * ((ys[1] - ys[2]) * u + (xs[2] - xs[1]) * v);
		w[1] = det * ((ys[2] - ys[0]) * u + (xs[0] - xs[2]) * v);
		w[2] = 64'sd65536 - w[0] - w[1];
		for (int s = 0; s < 2; s++) begin
			ax = 0;
			ay = 0;
			for (int k = 0; k < 3; k++) begin
				a = int'(xs[k] * NPTS + ys[k]);
				ax += w[k] * longint'(grid_x[s][a]);
				ay += w[k] * longint'(grid_y[s][a]);
			end
			if (s == SEL_DEP) begin
				r.dep_x = round_sat(ax);
				r.dep_y = round_sat(ay);
			end else if (it.with_ep) begin
				r.ep_x = round_sat(ax);
				r.ep_y = round_sat(ay);
			end
		end
		return r;
	endfunction

	task automatic send(in_item_t it, int gap, bit typed = 1'b0, out_item_t want = '0);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (busy);
		if (it.kind == KIND_LOAD) begin
			grid_x[it.table_select][it.grid_col*NPTS + it.grid_row] = it.load_x;
			grid_y[it.table_select][it.grid_col*NPTS + it.grid_row] = it.load_y;
		end else begin
			pending_results.insert(pending_results.size(), typed ? want : interpolate(it));
		end
	endtask

	task automatic drain_and_write(logic [31:0] val);
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		inv_spacing_q = val;
	endtask

	function automatic logic signed [31:0] rand_val();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return $urandom_range(0, 1) ? 32'sh10000 : -32'sh10000;
			default: return $urandom;
		endcase
	endfunction

	// aim inside the loaded window, or well off the grid
	function automatic logic signed [31:0] aim_pos();
		longint rel, p;
		if (inv_spacing_q == 0) return $urandom;
		if ($urandom_range(0, 4) == 0) begin
			rel = longint'($urandom_range(34 << 16, 40 << 16));
			if ($urandom_range(0, 1)) rel = -rel;
		end else begin
			rel = longint'($urandom_range(1024, (13 << 16) - 1024)) - (longint'(6) <<< 16);
		end
		p = (rel <<< 32) / longint'({32'b0, inv_spacing_q});
		if (p > 64'sd2147483647) p = 64'sd2147483647;
		if (p < -64'sd2147483648) p = -64'sd2147483648;
		return p[31:0];
	endfunction

	function automatic in_item_t rand_item();
		in_item_t it;
		it = '0;
		it.kind = ($urandom_range(0, 4) == 0) ? KIND_LOAD : KIND_QUERY;
		it.table_select = $urandom_range(0, 1);
		it.grid_col = $urandom;
		it.grid_row = $urandom;
		it.load_x = rand_val();
		it.load_y = rand_val();
		it.pos_x = aim_pos();
		it.pos_y = aim_pos();
		it.with_ep = $urandom_range(0, 1);
		return it;
	endfunction

	function automatic in_item_t load_of(logic sel, int c, int r, int x, int y);
		in_item_t it;
		it = '0;
		it.kind = KIND_LOAD;
		it.table_select = sel;
		it.grid_col = c;
		it.grid_row = r;
		it.load_x = x;
		it.load_y = y;
		return it;
	endfunction

	function automatic in_item_t query_of(int px, int py, logic ep);
		in_item_t it;
		it = '0;
		it.kind = KIND_QUERY;
		it.pos_x = px;
		it.pos_y = py;
		it.with_ep = ep;
		return it;
	endfunction

	function automatic stim_row_t row_of(in_item_t it, bit typed, out_item_t want);
		stim_row_t r;
		r.item = it;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result %p", $realtime, result);
				failed = 1'b1;
			end else begin
				if (result.dep_x !== pending_results[0].dep_x
						|| result.dep_y !== pending_results[0].dep_y
						|| result.ep_x !== pending_results[0].ep_x
						|| result.ep_y !== pending_results[0].ep_y
						|| result.out_of_grid !== pending_results[0].out_of_grid) begin
					$display("%0t mismatch: expected %p actual %p", $realtime,
						pending_results[0], result);
					failed = 1'b1;
				end
				void'(pending_results.pop_front());
			end
		end
	end

	initial begin
		#5ms;
		$display("** grid_field_barycentric_interp_core: FAILED **");
		$finish;
	end

	initial begin
		stim_row_t rows [$];
		out_item_t off_grid;
		logic [31:0] settings [6];
		off_grid = '0;
		off_grid.out_of_grid = 1'b1;
		settings = '{32'd0, 32'hFFFFFFFF, 32'h01000000, 32'h10000000,
			$urandom_range(32'hFFFFFFFF, 32'h00800000),
			$urandom_range(32'hFFFFFFFF, 32'h00800000)};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int s = 0; s < 2; s++) begin
			for (int c = WLO; c <= WHI; c++)
				for (int r = WLO; r <= WHI; r++)
					send(load_of(s, c, r, rand_val(), rand_val()), 0);
			for (int b = 0; b < 3; b++)
				for (int c = 0; c < 2; c++)
					for (int r = 0; r < 2; r++)
						send(load_of(s, (b == 1 ? NPTS - 2 : 0) + c,
							(b == 0 ? 0 : NPTS - 2) + r, rand_val(), rand_val()), 0);
		end

		rows.insert(rows.size(), row_of(query_of(0, 0, 1'b1), 1'b0, '0));
		rows.insert(rows.size(),
			row_of(query_of(32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b1), 1'b1, off_grid));
		rows.insert(rows.size(),
			row_of(query_of(32'sh80000000, 32'sh80000000, 1'b1), 1'b1, off_grid));
		rows.insert(rows.size(), row_of(query_of(32'sh7FFFFFFF, 0, 1'b0), 1'b1, off_grid));
		rows.insert(rows.size(), row_of(query_of(0, 32'sh80000000, 1'b0), 1'b1, off_grid));
		rows.insert(rows.size(),
			row_of(load_of(SEL_DEP, 0, 0, 32'sh7FFFFFFF, 32'sh80000000), 1'b0, '0));
		rows.insert(rows.size(),
			row_of(load_of(SEL_EP, 63, 63, 32'sh80000000, 32'sh7FFFFFFF), 1'b0, '0));
		rows.insert(rows.size(),
			row_of(query_of(-30800 <<< 16, -30800 <<< 16, 1'b1), 1'b0, '0));
		rows.insert(rows.size(),
			row_of(query_of(31900 <<< 16, 31900 <<< 16, 1'b1), 1'b0, '0));
		for (int c = 31; c <= 32; c++)
			for (int r = 31; r <= 32; r++) begin
				rows.insert(rows.size(), row_of(load_of(SEL_DEP, c, r, 32'sh7FFFFFFF,
					32'sh80000000), 1'b0, '0));
				rows.insert(rows.size(), row_of(load_of(SEL_EP, c, r, 32'sh7FFFFFFF,
					32'sh7FFFFFFF), 1'b0, '0));
			end
		rows.insert(rows.size(), row_of(query_of(250 <<< 16, 250 <<< 16, 1'b1), 1'b0, '0));
		rows.insert(rows.size(), row_of(query_of(500 <<< 16, 499 <<< 16, 1'b1), 1'b0, '0));
		rows.insert(rows.size(), row_of(query_of(740 <<< 16, 260 <<< 16, 1'b0), 1'b0, '0));
		rows.insert(rows.size(),
			row_of(query_of(-31000 <<< 16, 32000 <<< 16, 1'b1), 1'b0, '0));
		foreach (rows[i])
			send(rows[i].item, $urandom_range(0, 11), rows[i].typed, rows[i].want);

		for (int p = 0; p < 7; p++) begin
			if (p > 0) drain_and_write(settings[p - 1]);
			calm = $urandom_range(0, 1);
			repeat (200)
				send(rand_item(), calm ? 0 : $urandom_range(0, 11));
		end

		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (!failed)
			$display("** grid_field_barycentric_interp_core: PASSED **");
		else
			$display("** grid_field_barycentric_interp_core: FAILED **");
		$finish;
	end
endmodule
